// File: design/pga_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pga_pkg
// Shared types and constants for the prime gap extremes block.
// ----------------------------------------------------------------------------
package pga_pkg;

  localparam int unsigned SegmentSize = 1048576;
  localparam int unsigned BaseLimit   = 46340;
  localparam int unsigned FieldW      = 31;

  typedef enum logic [1:0] {
    STATUS_PAIRS   = 2'd0,
    STATUS_FEW     = 2'd1,
    STATUS_INVALID = 2'd2
  } status_e;

  // one classified query as it travels from front to back
  typedef struct packed {
    logic [FieldW-1:0] low;
    logic [FieldW-1:0] high;
    logic              invalid;
  } query_t;

endpackage

// File: design/pga_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pga_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pga_ram #(
  parameter int unsigned Width = 1,
  parameter int unsigned Depth = 2
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: design/pga_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pga_front
// Accepts queries and classifies them as valid or invalid ranges.
// ----------------------------------------------------------------------------
module pga_front #(
  parameter int unsigned SEGMENT_SIZE = pga_pkg::SegmentSize
) (
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [pga_pkg::FieldW-1:0]  range_low_i,
  input  logic [pga_pkg::FieldW-1:0]  range_high_i,
  output logic                        push_o,
  input  logic                        full_i,
  output pga_pkg::query_t             query_o
);

  logic [31:0] len;

  // range length and classification
  assign len = {1'b0, range_high_i} - {1'b0, range_low_i} + 32'd1;

  assign in_stall_o       = full_i;
  assign push_o           = in_valid_i && !full_i;
  assign query_o.low      = range_low_i;
  assign query_o.high     = range_high_i;
  assign query_o.invalid  = (range_high_i < range_low_i) || (len > 32'(SEGMENT_SIZE));

endmodule

// File: design/pga_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pga_queue
// Two-entry queue of classified queries between front and back.
// ----------------------------------------------------------------------------
module pga_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  pga_pkg::query_t push_data_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            pop_valid_o,
  output pga_pkg::query_t pop_data_o
);

  pga_pkg::query_t entry_q [2];
  logic            wptr_q, wptr_d;
  logic            rptr_q, rptr_d;
  logic [1:0]      cnt_q, cnt_d;

  assign full_o      = (cnt_q == 2'd2);
  assign pop_valid_o = (cnt_q != 2'd0);
  assign pop_data_o  = entry_q[rptr_q];

  // pointer and fill count
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) begin
      wptr_d = !wptr_q;
    end
    if (pop_i) begin
      rptr_d = !rptr_q;
    end
    cnt_d = cnt_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wptr_q] <= push_data_i;
    end
  end

endmodule

// File: design/pga_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pga_back
// Sieve engine: fills the segment, strikes multiples, scans for gaps.
// ----------------------------------------------------------------------------
module pga_back #(
  parameter int unsigned SEGMENT_SIZE = pga_pkg::SegmentSize,
  parameter int unsigned BASE_LIMIT   = pga_pkg::BaseLimit
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        pop_valid_i,
  input  pga_pkg::query_t             pop_data_i,
  output logic                        pop_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [1:0]                  status_o,
  output logic [pga_pkg::FieldW-1:0]  closest_small_o,
  output logic [pga_pkg::FieldW-1:0]  closest_large_o,
  output logic [pga_pkg::FieldW-1:0]  distant_small_o,
  output logic [pga_pkg::FieldW-1:0]  distant_large_o
);

  localparam int unsigned AW = $clog2(SEGMENT_SIZE);
  localparam int unsigned FW = pga_pkg::FieldW;

  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_FILL  = 9'b000000010,
    ST_SQ    = 9'b000000100,
    ST_CHECK = 9'b000001000,
    ST_DIV   = 9'b000010000,
    ST_START = 9'b000100000,
    ST_MARK  = 9'b001000000,
    ST_SCAN  = 9'b010000000,
    ST_DONE  = 9'b100000000
  } state_e;

  state_e          state_q, state_d;
  logic [FW-1:0]   low_q, high_q;
  logic [AW-1:0]   span_q, idx_q, idx_d;
  logic [16:0]     d_q, d_d;
  logic            step4_q, step4_d;
  logic [33:0]     sq_q;
  logic [16:0]     rem_q, rem_d;
  logic [4:0]      bit_q, bit_d;
  logic [31:0]     m_q, m_d;
  logic            drain_q, drain_d;
  pga_pkg::status_e res_status_q, res_status_d;

  logic            pend_q;
  logic [FW-1:0]   pend_n_q;
  logic [1:0]      cnt_q;
  logic [FW-1:0]   prev_q, min_gap_q, max_gap_q;
  logic [FW-1:0]   cs_q, cl_q, ds_q, dl_q;

  logic            out_valid_q;
  logic            load;
  logic            we;
  logic [AW-1:0]   waddr;
  logic            wdata;
  logic            rdata;
  logic [17:0]     rs;
  logic [31:0]     start;
  logic            prime_hit;
  logic [FW-1:0]   gap;

  // segment mark memory
  pga_ram #(.Width(1), .Depth(SEGMENT_SIZE)) u_marks (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (idx_q),
    .rdata_o (rdata)
  );

  // divider step and first multiple
  assign rs    = {rem_q, low_q[bit_q]};
  assign start = (rem_q == 17'd0) ? {1'b0, low_q}
               : {1'b0, low_q} + {15'd0, d_q} - {15'd0, rem_q};

  assign load  = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);
  assign pop_o = (state_q == ST_IDLE) && pop_valid_i;

  // sequencer
  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    d_d          = d_q;
    step4_d      = step4_q;
    rem_d        = rem_q;
    bit_d        = bit_q;
    m_d          = m_q;
    drain_d      = 1'b0;
    res_status_d = res_status_q;
    we           = 1'b0;
    waddr        = idx_q;
    wdata        = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        if (pop_valid_i) begin
          idx_d = '0;
          if (pop_data_i.invalid) begin
            res_status_d = pga_pkg::STATUS_INVALID;
            state_d      = ST_DONE;
          end else begin
            state_d = ST_FILL;
          end
        end
      end
      ST_FILL: begin
        we = 1'b1;
        if (idx_q == span_q) begin
          d_d     = 17'd2;
          state_d = ST_SQ;
        end else begin
          idx_d = idx_q + AW'(1);
        end
      end
      ST_SQ: begin
        state_d = ST_CHECK;
      end
      ST_CHECK: begin
        if (d_q >= 17'(BASE_LIMIT) || sq_q > {3'd0, high_q}) begin
          idx_d   = '0;
          state_d = ST_SCAN;
        end else begin
          rem_d   = '0;
          bit_d   = 5'(FW - 1);
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        rem_d = (rs >= {1'b0, d_q}) ? 17'(rs - {1'b0, d_q}) : rs[16:0];
        if (bit_q == 5'd0) begin
          state_d = ST_START;
        end else begin
          bit_d = bit_q - 5'd1;
        end
      end
      ST_START: begin
        m_d     = ({2'b0, start} < sq_q) ? sq_q[31:0] : start;
        state_d = ST_MARK;
      end
      ST_MARK: begin
        if (m_q > {1'b0, high_q}) begin
          // next trial divisor: 2, 3, then 6k-1 and 6k+1
          priority if (d_q == 17'd2) begin
            d_d = 17'd3;
          end else if (d_q == 17'd3) begin
            d_d     = 17'd5;
            step4_d = 1'b0;
          end else begin
            d_d     = d_q + (step4_q ? 17'd4 : 17'd2);
            step4_d = !step4_q;
          end
          state_d = ST_SQ;
        end else begin
          we    = 1'b1;
          wdata = 1'b0;
          waddr = AW'(m_q - {1'b0, low_q});
          m_d   = m_q + {15'd0, d_q};
        end
      end
      ST_SCAN: begin
        if (drain_q) begin
          // the last number of the range is counted in this same cycle
          res_status_d = (cnt_q == 2'd2 || (cnt_q == 2'd1 && prime_hit))
                       ? pga_pkg::STATUS_PAIRS : pga_pkg::STATUS_FEW;
          state_d      = ST_DONE;
        end else if (idx_q == span_q) begin
          drain_d = 1'b1;
        end else begin
          idx_d = idx_q + AW'(1);
        end
      end
      ST_DONE: begin
        if (load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pend_q      <= 1'b0;
      drain_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      drain_q <= drain_d;
      pend_q  <= (state_q == ST_SCAN) && !drain_q;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    idx_q        <= idx_d;
    d_q          <= d_d;
    step4_q      <= step4_d;
    rem_q        <= rem_d;
    bit_q        <= bit_d;
    m_q          <= m_d;
    res_status_q <= res_status_d;
    sq_q         <= {17'd0, d_q} * {17'd0, d_q};
    pend_n_q     <= low_q + FW'(idx_q);
    if (pop_o) begin
      low_q  <= pop_data_i.low;
      high_q <= pop_data_i.high;
      span_q <= AW'(pop_data_i.high - pop_data_i.low);
    end
  end

  // gap tracking over the primes as they stream out of the scan
  assign prime_hit = pend_q && rdata && (pend_n_q >= FW'(2));
  assign gap       = pend_n_q - prev_q;

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cnt_q <= 2'd0;
    end else if (prime_hit) begin
      prev_q <= pend_n_q;
      cnt_q  <= (cnt_q == 2'd0) ? 2'd1 : 2'd2;
      if (cnt_q != 2'd0) begin
        if (cnt_q == 2'd1 || gap > max_gap_q) begin
          max_gap_q <= gap;
          ds_q      <= prev_q;
          dl_q      <= pend_n_q;
        end
        if (cnt_q == 2'd1 || gap < min_gap_q) begin
          min_gap_q <= gap;
          cs_q      <= prev_q;
          cl_q      <= pend_n_q;
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (load) begin
      status_o <= res_status_q;
      if (res_status_q == pga_pkg::STATUS_PAIRS) begin
        closest_small_o <= cs_q;
        closest_large_o <= cl_q;
        distant_small_o <= ds_q;
        distant_large_o <= dl_q;
      end else begin
        closest_small_o <= '0;
        closest_large_o <= '0;
        distant_small_o <= '0;
        distant_large_o <= '0;
      end
    end
  end

  assign out_valid_o = out_valid_q;

  // marks are written only while filling or striking
  a_write_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |-> (state_q == ST_FILL || state_q == ST_MARK))
    else $error("mark write outside fill or strike");

  // the queue is drained only by an idle engine
  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> (state_q == ST_IDLE && pop_valid_i))
    else $error("query taken while busy");

  // a loaded result is presented on the next cycle
  a_load_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> out_valid_o)
    else $error("result lost on load");

  // a result is never loaded over one still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !load)
    else $error("result overwritten");

endmodule

// File: design/prime_gap_extremes_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prime_gap_extremes_top
// Closest and most distant adjacent primes of a query range.
// ----------------------------------------------------------------------------
// Each query [low, high] gives one result. An invalid range (high below low,
// or more than SEGMENT_SIZE numbers) goes straight to the result. A valid
// range is worked in turn: the marks are set for every number, the multiples
// of each trial divisor 2, 3 and 6k+-1 up to sqrt(high) are struck, after a
// bit-serial remainder and setup per divisor, and the range is scanned; the
// single write port of the mark memory sets the pace of marking and striking.
// Two further queries may wait in the input queue while one is worked on,
// and a finished result waits in the output register.
module prime_gap_extremes_top #(
  parameter int unsigned SEGMENT_SIZE = pga_pkg::SegmentSize,
  parameter int unsigned BASE_LIMIT   = pga_pkg::BaseLimit
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [pga_pkg::FieldW-1:0]  range_low_i,
  input  logic [pga_pkg::FieldW-1:0]  range_high_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [1:0]                  status_o,
  output logic [pga_pkg::FieldW-1:0]  closest_small_o,
  output logic [pga_pkg::FieldW-1:0]  closest_large_o,
  output logic [pga_pkg::FieldW-1:0]  distant_small_o,
  output logic [pga_pkg::FieldW-1:0]  distant_large_o
);

  logic            push, full, pop, pop_valid;
  pga_pkg::query_t push_data, pop_data;

  // front: accept and classify
  pga_front #(.SEGMENT_SIZE(SEGMENT_SIZE)) u_front (
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .range_low_i  (range_low_i),
    .range_high_i (range_high_i),
    .push_o       (push),
    .full_i       (full),
    .query_o      (push_data)
  );

  // queue between front and back
  pga_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .pop_valid_o (pop_valid),
    .pop_data_o  (pop_data)
  );

  // back: sieve and scan
  pga_back #(.SEGMENT_SIZE(SEGMENT_SIZE), .BASE_LIMIT(BASE_LIMIT)) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .pop_valid_i     (pop_valid),
    .pop_data_i      (pop_data),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_o        (status_o),
    .closest_small_o (closest_small_o),
    .closest_large_o (closest_large_o),
    .distant_small_o (distant_small_o),
    .distant_large_o (distant_large_o)
  );

endmodule

// File: sim/tb_prime_gap_extremes_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_prime_gap_extremes_top
// Self-checking bench for the prime gap extremes block.
// ----------------------------------------------------------------------------
// Query ranges go in from a pending queue through a clocked driver. Each
// accepted query is solved in the bench by a plain segment sieve, and the
// answer is queued. A clocked monitor checks each result transfer, field by
// field, against the oldest queued answer. Both sides idle at random, and
// the result side holds off for a long stretch at the start so that the
// input queue fills and the block stalls its input.
module tb_prime_gap_extremes_top;

  localparam int unsigned MaxCycles = 10000000;
  localparam int unsigned HoldCycles = 400;
  localparam logic [pga_pkg::FieldW-1:0] FieldMax = {pga_pkg::FieldW{1'b1}};

  typedef struct {
    logic [pga_pkg::FieldW-1:0] low;
    logic [pga_pkg::FieldW-1:0] high;
  } range_t;

  typedef struct {
    pga_pkg::status_e           status;
    logic [pga_pkg::FieldW-1:0] cs;
    logic [pga_pkg::FieldW-1:0] cl;
    logic [pga_pkg::FieldW-1:0] ds;
    logic [pga_pkg::FieldW-1:0] dl;
  } gap_answer_t;

  logic                       clk_i;
  logic                       rst_ni;
  logic                       in_valid_i;
  logic                       in_stall_o;
  logic [pga_pkg::FieldW-1:0] range_low_i;
  logic [pga_pkg::FieldW-1:0] range_high_i;
  logic                       out_valid_o;
  logic                       out_stall_i;
  logic [1:0]                 status_o;
  logic [pga_pkg::FieldW-1:0] closest_small_o;
  logic [pga_pkg::FieldW-1:0] closest_large_o;
  logic [pga_pkg::FieldW-1:0] distant_small_o;
  logic [pga_pkg::FieldW-1:0] distant_large_o;

  range_t      pending_q[$];
  gap_answer_t answer_q[$];
  int unsigned errors;
  int unsigned queries_sent;
  int unsigned results_seen;
  int unsigned status_seen[3];
  int unsigned cycles;
  int unsigned send_gap;
  int unsigned recv_gap;
  int unsigned hold_left;
  logic        gap_stall;
  logic        hold_stall;

  prime_gap_extremes_top i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .range_low_i    (range_low_i),
    .range_high_i   (range_high_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .closest_small_o(closest_small_o),
    .closest_large_o(closest_large_o),
    .distant_small_o(distant_small_o),
    .distant_large_o(distant_large_o)
  );

  assign out_stall_i = gap_stall | hold_stall;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // closest and most distant adjacent primes of [low, high]
  function automatic gap_answer_t sieve_gap_extremes(range_t q);
    gap_answer_t res;
    bit          marks[];
    longint      lo, hi, len, d, m, n, prev, gap, min_gap, max_gap;
    int unsigned count;
    lo = q.low;
    hi = q.high;
    res = '{pga_pkg::STATUS_INVALID, '0, '0, '0, '0};
    if (hi < lo || hi - lo + 1 > pga_pkg::SegmentSize) return res;
    len = hi - lo + 1;
    marks = new[len];
    foreach (marks[i]) marks[i] = 1'b1;
    for (n = lo; n <= hi && n < 2; n++) marks[n - lo] = 1'b0;
    // strike every multiple of d from d*d upward; composite d adds nothing
    for (d = 2; d * d <= hi; d++) begin
      m = ((lo + d - 1) / d) * d;
      if (m < d * d) m = d * d;
      for (; m <= hi; m += d) marks[m - lo] = 1'b0;
    end
    count = 0;
    prev = 0;
    min_gap = 0;
    max_gap = 0;
    for (n = lo; n <= hi; n++) begin
      if (!marks[n - lo]) continue;
      if (count > 0) begin
        gap = n - prev;
        if (count == 1 || gap > max_gap) begin
          max_gap = gap; res.ds = prev; res.dl = n;
        end
        if (count == 1 || gap < min_gap) begin
          min_gap = gap; res.cs = prev; res.cl = n;
        end
      end
      prev = n;
      count++;
    end
    if (count < 2) res = '{pga_pkg::STATUS_FEW, '0, '0, '0, '0};
    else res.status = pga_pkg::STATUS_PAIRS;
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [pga_pkg::FieldW-1:0] got,
                                 logic [pga_pkg::FieldW-1:0] want);
    $display("result %0d: %s got %0d expected %0d", results_seen, what, got, want);
    errors++;
  endtask

  // input driver
  always @(posedge clk_i or negedge rst_ni) begin
    range_t cur;
    if (!rst_ni) begin
      in_valid_i   <= 1'b0;
      range_low_i  <= '0;
      range_high_i <= '0;
      send_gap     = 0;
      queries_sent = 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        cur.low  = range_low_i;
        cur.high = range_high_i;
        answer_q.push_back(sieve_gap_extremes(cur));
        queries_sent++;
      end
      if (!(in_valid_i && in_stall_o)) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (pending_q.size() > 0) begin
          cur = pending_q.pop_front();
          range_low_i  <= cur.low;
          range_high_i <= cur.high;
          in_valid_i   <= 1'b1;
          send_gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 17);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // long hold-off on the result side right after reset
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_stall <= 1'b1;
      hold_left  = HoldCycles;
    end else if (hold_left > 0) begin
      hold_left--;
      hold_stall <= 1'b1;
    end else begin
      hold_stall <= 1'b0;
    end
  end

  // result monitor
  always @(posedge clk_i or negedge rst_ni) begin
    gap_answer_t want;
    if (!rst_ni) begin
      gap_stall    <= 1'b0;
      recv_gap     = 0;
      results_seen = 0;
      errors       = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        results_seen++;
        if (answer_q.size() == 0) begin
          $display("result %0d: transfer with no query outstanding", results_seen);
          errors++;
        end else begin
          want = answer_q.pop_front();
          if (status_o <= 2) status_seen[status_o]++;
          if (status_o != want.status) report_mismatch("status", status_o, want.status);
          if (closest_small_o != want.cs)
            report_mismatch("closest_small", closest_small_o, want.cs);
          if (closest_large_o != want.cl)
            report_mismatch("closest_large", closest_large_o, want.cl);
          if (distant_small_o != want.ds)
            report_mismatch("distant_small", distant_small_o, want.ds);
          if (distant_large_o != want.dl)
            report_mismatch("distant_large", distant_large_o, want.dl);
        end
        recv_gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 17);
      end
      if (recv_gap > 0) begin
        recv_gap--;
        gap_stall <= 1'b1;
      end else begin
        gap_stall <= 1'b0;
      end
    end
  end

  // timeout
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cycles = 0;
    end else begin
      cycles++;
      if (cycles > MaxCycles) begin
        $display("timeout after %0d cycles", cycles);
        $display("prime_gap_extremes_top: mismatch");
        $finish;
      end
    end
  end

  task automatic add_range(longint lo, longint hi);
    range_t r;
    r.low  = lo[pga_pkg::FieldW-1:0];
    r.high = hi[pga_pkg::FieldW-1:0];
    pending_q.push_back(r);
  endtask

  // stimulus and end of run
  initial begin
    longint lo, span;
    int unsigned kind;
    status_seen = '{0, 0, 0};
    rst_ni = 1'b0;
    // cheap queries first so the input side backs up during the hold-off
    add_range(5, 3);
    add_range(FieldMax, 0);
    add_range(FieldMax, 1);
    add_range(1, pga_pkg::SegmentSize + 1);
    add_range(0, FieldMax);
    add_range(0, 0);
    add_range(1, 1);
    add_range(0, 2);
    add_range(2, 3);
    add_range(3, 5);
    add_range(0, 30);
    add_range(1, 100);
    add_range(24, 28);
    add_range(90, 96);
    add_range(113, 127);
    add_range(46337, 46400);
    add_range(1000000, 1000100);
    add_range(2000, 5000);
    add_range(1073741789, 1073741860);
    add_range(64'd2147483547, FieldMax);
    // random part: mostly small valid ranges, some full-width invalid ones
    for (int i = 0; i < 80; i++) begin
      kind = $urandom_range(0, 9);
      if (kind < 7) begin
        lo = $urandom_range(0, (1 << $urandom_range(1, 20)) - 1);
        span = $urandom_range(0, 200);
        add_range(lo, lo + span);
      end else if (kind < 9) begin
        lo = $urandom_range(1, FieldMax);
        add_range(lo, $urandom_range(0, lo - 1));
      end else begin
        lo = $urandom_range(0, FieldMax - pga_pkg::SegmentSize - 1);
        add_range(lo, lo + pga_pkg::SegmentSize
                  + $urandom_range(0, FieldMax - lo - pga_pkg::SegmentSize));
      end
    end
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (pending_q.size() > 0 || in_valid_i) @(posedge clk_i);
    while (answer_q.size() > 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    $display("%0d queries sent, %0d results checked in %0d cycles", queries_sent,
             results_seen, cycles);
    $display("results with pairs %0d, too few primes %0d, rejected ranges %0d",
             status_seen[0], status_seen[1], status_seen[2]);
    if (errors == 0) begin
      $display("prime_gap_extremes_top: match");
    end else begin
      $display("prime_gap_extremes_top: mismatch");
    end
    $finish;
  end

endmodule

// File: files.f
design/pga_pkg.sv
design/pga_ram.sv
design/pga_front.sv
design/pga_queue.sv
design/pga_back.sv
design/prime_gap_extremes_top.sv
sim/tb_prime_gap_extremes_top.sv
